// ----- design/rmst_pkg.sv -----
package rmst_pkg;

  localparam int SLOTS_DEF       = 1024;
  localparam int VALUE_BITS_DEF  = 20;
  localparam int INDEX_BITS      = 10;
  localparam int VALUE_PORT_BITS = 20;
  localparam int CFG_INDEX_BITS  = 1;

  localparam logic [INDEX_BITS-1:0] LAST_INDEX_RESET = 10'd1023;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BANK0_LAST = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BANK1_LAST = 1'b1;

  // request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_UP,
    ST_Q_RUN
  } rmst_state_t;

  typedef struct packed {
    logic strobe;
    logic found;
  } rmst_res_t;

endpackage

// ----- design/rmst_node_ram.sv -----
module rmst_node_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 20
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [DATA_BITS-1:0] rdata_a,
  output logic [DATA_BITS-1:0] rdata_b
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/rmst_ctrl.sv -----
module rmst_ctrl import rmst_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NW         = $clog2(SLOTS) + 1,
  parameter int AW         = NW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  operation,
  input  logic                  bank,
  input  logic [INDEX_BITS-1:0] slot_index,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  logic [INDEX_BITS-1:0] range_low,
  input  logic [INDEX_BITS-1:0] range_high,
  input  logic [INDEX_BITS-1:0] last0,
  input  logic [INDEX_BITS-1:0] last1,
  output logic                  busy,
  output rmst_res_t             res,
  output logic [VALUE_BITS-1:0] res_value,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [VALUE_BITS-1:0] wdata,
  output logic [AW-1:0]         raddr_a,
  output logic [AW-1:0]         raddr_b,
  input  logic [VALUE_BITS-1:0] rdata_a,
  input  logic [VALUE_BITS-1:0] rdata_b
);

  localparam int RW = NW + 1;
  localparam logic [INDEX_BITS-1:0] SLOT_CAP =
    (SLOTS > 2**INDEX_BITS) ? {INDEX_BITS{1'b1}} : INDEX_BITS'(SLOTS - 1);

  rmst_state_t state, state_next;
  logic [AW-1:0]         clr_addr, clr_addr_next;
  logic                  bank_q, bank_q_next;
  logic [NW-1:0]         pos, pos_next;
  logic [VALUE_BITS-1:0] cur, cur_next;
  logic [RW-1:0]         l, l_next, r, r_next;
  logic [VALUE_BITS-1:0] best, best_next;
  logic                  pend, pend_next;
  logic                  take_l, take_l_next, take_r, take_r_next;

  logic [INDEX_BITS-1:0] last_sel, last_eff, hi_clip;
  logic [NW-1:0]         leaf, up;
  logic [VALUE_BITS-1:0] cand_a, cand_b, merged_a, merged, parent;

  assign busy     = (state != ST_IDLE);
  assign last_sel = bank ? last1 : last0;
  assign last_eff = (last_sel > SLOT_CAP) ? SLOT_CAP : last_sel;
  assign hi_clip  = (range_high > last_eff) ? last_eff : range_high;
  assign leaf     = NW'(slot_index) + NW'(SLOTS);
  assign up       = pos >> 1;
  assign parent   = (cur > rdata_a) ? cur : rdata_a;
  assign cand_a   = (pend && take_l) ? rdata_a : '0;
  assign cand_b   = (pend && take_r) ? rdata_b : '0;
  assign merged_a = (cand_a > best) ? cand_a : best;
  assign merged   = (cand_b > merged_a) ? cand_b : merged_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend     <= pend_next;
    end
    bank_q <= bank_q_next;
    pos    <= pos_next;
    cur    <= cur_next;
    l      <= l_next;
    r      <= r_next;
    best   <= best_next;
    take_l <= take_l_next;
    take_r <= take_r_next;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    bank_q_next   = bank_q;
    pos_next      = pos;
    cur_next      = cur;
    l_next        = l;
    r_next        = r;
    best_next     = best;
    pend_next     = 1'b0;
    take_l_next   = take_l;
    take_r_next   = take_r;
    we            = 1'b0;
    waddr         = clr_addr;
    wdata         = '0;
    raddr_a       = {bank_q, NW'(l)};
    raddr_b       = {bank_q, r[NW-1:1], 1'b0};
    res           = '0;
    res_value     = '0;
    unique case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          bank_q_next = bank;
          if (operation == OP_WRITE) begin
            if (slot_index <= last_eff) begin
              // store the leaf, fetch its sibling
              we         = 1'b1;
              waddr      = {bank, leaf};
              wdata      = wr_value;
              raddr_a    = {bank, leaf ^ NW'(1)};
              pos_next   = leaf;
              cur_next   = wr_value;
              state_next = ST_WR_UP;
            end else begin
              res.strobe = 1'b1;
            end
          end else begin
            if (range_low <= hi_clip) begin
              l_next     = RW'(range_low) + RW'(SLOTS);
              r_next     = RW'(hi_clip) + RW'(SLOTS) + RW'(1);
              best_next  = '0;
              state_next = ST_Q_RUN;
            end else begin
              res.strobe = 1'b1;
            end
          end
        end
      end
      ST_WR_UP: begin
        we       = 1'b1;
        waddr    = {bank_q, up};
        wdata    = parent;
        pos_next = up;
        cur_next = parent;
        raddr_a  = {bank_q, up ^ NW'(1)};
        if (up == NW'(1)) begin
          res.strobe = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_Q_RUN: begin
        best_next = merged;
        if (l < r) begin
          take_l_next = l[0];
          take_r_next = r[0];
          pend_next   = 1'b1;
          l_next      = (l + RW'(l[0])) >> 1;
          r_next      = r >> 1;
        end else if (!pend) begin
          res.strobe = 1'b1;
          res.found  = (best != '0);
          res_value  = best;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_wr_not_node_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_UP) |-> (up != '0))
    else $error("tree update writes node zero");

  a_query_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_RUN) |-> (l <= r))
    else $error("query left bound passed right bound");

  a_clear_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && state_next == ST_IDLE) |-> (clr_addr == {AW{1'b1}}))
    else $error("clearing pass ended early");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.found |-> (res.strobe && res_value != '0))
    else $error("found flagged without a positive value");
`endif

endmodule

// ----- design/range_max_segment_tree_core.sv -----
// Two-bank range-maximum store built on bottom-up segment trees.
//
// Request channel: present operation, bank, slot_index, slot_value, range_low
// and range_high with start high; the request is taken at a rising edge where
// start is high and busy is low. A write (operation 0) stores slot_value at
// slot_index; a query (operation 1) returns the largest positive value within
// range_low..range_high of the bank, clipped to the bank's last index.
// Result channel: done is high for exactly one cycle with max_value, found and
// ever_found; the receiver cannot stall it, so results are never held back.
// Configuration: cfg_valid with cfg_index/cfg_data writes a bank's last index;
// cfg_ready is always high. Write only while idle.
// Timing: one node-memory access per tree level sets the figures. A write
// takes clog2(SLOTS)+1 cycles to done (11 at 1024 slots), a query at most
// clog2(SLOTS)+4 (14), an ignored write or empty range 1 cycle. Busy drops as
// done rises, so the next request may be taken in the result cycle.
// Reset: a clearing pass zeroes the node memory, one entry a cycle, for
// 2^(clog2(SLOTS)+2) cycles (4096 at 1024 slots); busy stays high meanwhile.
// Configuration writes are taken as ever during the pass.
module range_max_segment_tree_core import rmst_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic                       bank,
  input  logic [INDEX_BITS-1:0]      slot_index,
  input  logic [VALUE_PORT_BITS-1:0] slot_value,
  input  logic [INDEX_BITS-1:0]      range_low,
  input  logic [INDEX_BITS-1:0]      range_high,
  output logic                       done,
  output logic [VALUE_PORT_BITS-1:0] max_value,
  output logic                       found,
  output logic                       ever_found,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [INDEX_BITS-1:0]      cfg_data
);

  localparam int NW = $clog2(SLOTS) + 1;
  localparam int AW = NW + 1;

  logic [INDEX_BITS-1:0] last0, last1;
  logic                  any_hit;
  rmst_res_t             res;
  logic [VALUE_BITS-1:0] res_value, wr_value;
  logic                  we;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;

  assign cfg_ready = 1'b1;
  // drop value bits above the stored width
  assign wr_value  = VALUE_BITS'(slot_value);

  // hold the per-bank last index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last0 <= LAST_INDEX_RESET;
      last1 <= LAST_INDEX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BANK0_LAST: last0 <= cfg_data;
        CFG_BANK1_LAST: last1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // register the result and advance the sticky hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      any_hit <= 1'b0;
    end else begin
      done <= res.strobe;
      if (res.found) begin
        any_hit <= 1'b1;
      end
    end
    max_value  <= VALUE_PORT_BITS'(res_value);
    found      <= res.found;
    ever_found <= any_hit | res.found;
  end

  rmst_ctrl #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS),
    .NW         (NW),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .bank       (bank),
    .slot_index (slot_index),
    .wr_value   (wr_value),
    .range_low  (range_low),
    .range_high (range_high),
    .last0      (last0),
    .last1      (last1),
    .busy       (busy),
    .res        (res),
    .res_value  (res_value),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b)
  );

  rmst_node_ram #(
    .ADDR_BITS (AW),
    .DATA_BITS (VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule
